// ----- design/rational_arith_reduce_defines.svh -----
// Assertion macros shared by the rational reduction block.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define RAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define RAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rar_pkg.sv -----
// Package for the rational arithmetic reduction block: payload types, codes,
// controller states and the command and status structs. No dependencies.
`default_nettype none
package rar_pkg;
  localparam int OPERAND_WIDTH = 16;
  localparam int IN_W = 16;
  localparam int RES_W = 32;
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]             action;
    logic signed [IN_W-1:0] a_num;
    logic signed [IN_W-1:0] a_den;
    logic signed [IN_W-1:0] b_num;
    logic signed [IN_W-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] raw_num;
    logic signed [RES_W-1:0] raw_den;
    logic signed [RES_W-1:0] red_num;
    logic signed [RES_W-1:0] red_den;
    logic                    zero_gcd;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_EUC_CHK,
    ST_EUC_DIV,
    ST_QN_DIV,
    ST_QD_DIV,
    ST_FIX,
    ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture input operands
    logic prod;       // form the products
    logic sum;        // combine into raw pair
    logic div_start;  // start one serial division
    logic [1:0] div_sel;  // operand selection for the division
    logic euc_step;   // take remainder into the Euclid pair
    logic qn_take;    // capture numerator quotient
    logic qd_take;    // capture denominator quotient
    logic fix;        // sign fix and result assembly
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic d_zero;
  } sts_t;

  localparam logic [1:0] DSEL_EUC = 2'd0;
  localparam logic [1:0] DSEL_QN  = 2'd1;
  localparam logic [1:0] DSEL_QD  = 2'd2;

  function automatic logic signed [RES_W-1:0] sext_op(input logic [IN_W-1:0] v);
    logic [OPERAND_WIDTH-1:0] t;
    t = v[OPERAND_WIDTH-1:0];
    return RES_W'(signed'(t));
  endfunction
endpackage
`default_nettype wire

// ----- design/rar_divider.sv -----
// Radix-2 restoring serial divider for truncating signed 32-bit division.
// Gives quotient and remainder one bit a cycle; uses rar_pkg.
`default_nettype none
module rar_divider (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [rar_pkg::RES_W-1:0] dividend,
  input  wire logic [rar_pkg::RES_W-1:0] divisor,
  output logic                         done,
  output logic [rar_pkg::RES_W-1:0]    quot,
  output logic [rar_pkg::RES_W-1:0]    rem
);
  import rar_pkg::*;
  `include "rational_arith_reduce_defines.svh"

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RES_W-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [RES_W:0]   p_r, p_nxt;
  logic             qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic             done_r, done_nxt;
  logic [RES_W:0]   shifted, diff;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    p_nxt    = p_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    done_nxt = 1'b0;
    shifted  = {p_r[RES_W-1:0], q_r[RES_W-1]};
    diff     = shifted - {1'b0, d_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend[RES_W-1] ? RES_W'(0) - dividend : dividend;
      d_nxt    = divisor[RES_W-1] ? RES_W'(0) - divisor : divisor;
      p_nxt    = '0;
      qneg_nxt = dividend[RES_W-1] ^ divisor[RES_W-1];
      rneg_nxt = dividend[RES_W-1];
    end else if (busy_r) begin
      if (!diff[RES_W]) begin
        p_nxt = diff;
        q_nxt = {q_r[RES_W-2:0], 1'b1};
      end else begin
        p_nxt = shifted;
        q_nxt = {q_r[RES_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(RES_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r    <= q_nxt;
    d_r    <= d_nxt;
    p_r    <= p_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign done = done_r;
  assign quot = qneg_r ? RES_W'(0) - q_r : q_r;
  assign rem  = rneg_r ? RES_W'(0) - p_r[RES_W-1:0] : p_r[RES_W-1:0];

  `RAR_ASSERT(a_done_not_busy, !(done_r && busy_r), "divider done while busy")
  `RAR_ASSERT_NEXT(a_start_busy, start, busy_r, "divider did not start")
  `RAR_ASSERT(a_cnt_range, cnt_r <= CNT_W'(RES_W), "divider count out of range")
endmodule
`default_nettype wire

// ----- design/rar_datapath.sv -----
// Datapath: operand registers, products, raw pair, Euclid pair and results.
// Uses rar_pkg and instantiates rar_divider.
`default_nettype none
module rar_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rar_pkg::in_item_t  in_item,
  input  wire rar_pkg::cmd_t      cmd,
  output rar_pkg::sts_t           sts,
  output rar_pkg::out_item_t      res
);
  import rar_pkg::*;

  logic [1:0]              op_r;
  logic signed [RES_W-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [RES_W-1:0] p0_r, p1_r, p2_r;
  logic [RES_W-1:0]        rn_r, rd_r, n_r, d_r, qn_r, qd_r;
  out_item_t               res_r;
  logic [RES_W-1:0]        dv_n, dv_d, quot, rem;
  logic                    div_done;
  logic signed [RES_W-1:0] m0, m1;

  // Second operands of the first and third products depend on the operation.
  always_comb begin
    m0 = bd_r;
    m1 = bd_r;
    case (op_t'(op_r))
      OP_MUL:  m0 = bn_r;
      OP_DIV:  m1 = bn_r;
      default: ;
    endcase
  end

  always_comb begin
    case (cmd.div_sel)
      DSEL_QN: begin dv_n = rn_r; dv_d = n_r; end
      DSEL_QD: begin dv_n = rd_r; dv_d = n_r; end
      default: begin dv_n = n_r;  dv_d = d_r; end
    endcase
  end

  rar_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(dv_n), .divisor(dv_d), .done(div_done), .quot(quot), .rem(rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_item.action;
      an_r <= sext_op(in_item.a_num);
      ad_r <= sext_op(in_item.a_den);
      bn_r <= sext_op(in_item.b_num);
      bd_r <= sext_op(in_item.b_den);
    end
    if (cmd.prod) begin
      p0_r <= RES_W'(an_r * m0);
      p1_r <= RES_W'(ad_r * bn_r);
      p2_r <= RES_W'(ad_r * m1);
    end
    if (cmd.sum) begin
      case (op_t'(op_r))
        OP_ADD:  rn_r <= p0_r + p1_r;
        OP_SUB:  rn_r <= p0_r - p1_r;
        default: rn_r <= p0_r;
      endcase
      rd_r <= p2_r;
      n_r  <= (op_t'(op_r) == OP_ADD) ? p0_r + p1_r :
              (op_t'(op_r) == OP_SUB) ? p0_r - p1_r : p0_r;
      d_r  <= p2_r;
    end
    if (cmd.euc_step) begin
      n_r <= d_r;
      d_r <= rem;
    end
    if (cmd.qn_take) qn_r <= quot;
    if (cmd.qd_take) qd_r <= quot;
    if (cmd.fix) begin
      res_r.raw_num  <= rn_r;
      res_r.raw_den  <= rd_r;
      res_r.zero_gcd <= (n_r == '0);
      if (n_r == '0) begin
        res_r.red_num <= '0;
        res_r.red_den <= '0;
      end else if (qd_r[RES_W-1]) begin
        res_r.red_num <= RES_W'(0) - qn_r;
        res_r.red_den <= RES_W'(0) - qd_r;
      end else begin
        res_r.red_num <= qn_r;
        res_r.red_den <= qd_r;
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.d_zero   = (d_r == '0);
  assign res          = res_r;
endmodule
`default_nettype wire

// ----- design/rar_ctrl.sv -----
// Controller state machine: sequences products, Euclid steps and quotients.
// Uses rar_pkg.
`default_nettype none
module rar_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire rar_pkg::sts_t sts,
  output rar_pkg::cmd_t      cmd
);
  import rar_pkg::*;
  `include "rational_arith_reduce_defines.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_EUC_CHK;
      end
      ST_EUC_CHK: begin
        if (sts.d_zero) begin
          // The gcd is in n_r. The quotients are taken even when it is zero
          // and are dropped at the sign fix.
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_QN;
          state_nxt     = ST_QN_DIV;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_EUC;
          state_nxt     = ST_EUC_DIV;
        end
      end
      ST_EUC_DIV: begin
        cmd.div_sel = DSEL_EUC;
        if (sts.div_done) begin
          cmd.euc_step = 1'b1;
          state_nxt    = ST_EUC_CHK;
        end
      end
      ST_QN_DIV: begin
        cmd.div_sel = DSEL_QN;
        if (sts.div_done) begin
          cmd.qn_take   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_QD;
          state_nxt     = ST_QD_DIV;
        end
      end
      ST_QD_DIV: begin
        cmd.div_sel = DSEL_QD;
        if (sts.div_done) begin
          cmd.qd_take = 1'b1;
          state_nxt   = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `RAR_ASSERT(a_ready_idle, !(in_ready && out_valid), "input ready while result pending")
  `RAR_ASSERT_NEXT(a_load_prod, cmd.load, state_r == ST_PROD, "load not followed by products")
  `RAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
endmodule
`default_nettype wire

// ----- design/rational_arith_reduce.sv -----
// Top level of the rational arithmetic block with reduction by the gcd.
// Uses rar_pkg; instantiates rar_ctrl and rar_datapath.
//
//   channel  ports                          payload
//   input    in_valid / in_ready            rar_pkg::in_item_t in_data
//   result   out_valid / out_ready          rar_pkg::out_item_t out_data
//
// One item at a time: the item is accepted, the products and raw pair are formed,
// then Euclid steps run on the shared serial divider (up to about 46 steps),
// each after a check state, then come the two quotient divisions, the sign fix
// and the output state.
// Reset is synchronous, active low.
// A stalled result holds in the output register until its transfer.
`default_nettype none
module rational_arith_reduce (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rar_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rar_pkg::out_item_t      out_data
);
  import rar_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rar_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  rar_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_data), .cmd(cmd), .sts(sts),
    .res(out_data)
  );
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for rational_arith_reduce: fraction add/sub/mul/div with gcd reduction.
// Depends on rar_pkg and the rational_arith_reduce RTL; self-contained otherwise.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import rar_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  out_item_t fraction_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  rational_arith_reduce dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  function automatic logic [31:0] magnitude(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [31:0] trunc_rem(logic [31:0] n, logic [31:0] d);
    logic [31:0] r;
    if (d == 0) return 0;
    r = magnitude(n) % magnitude(d);
    return n[31] ? -r : r;
  endfunction

  function automatic logic [31:0] trunc_quot(logic [31:0] n, logic [31:0] d);
    logic [31:0] q;
    if (d == 0) return 0;
    q = magnitude(n) / magnitude(d);
    return (n[31] ^ d[31]) ? -q : q;
  endfunction

  function automatic logic signed [63:0] operand(logic [15:0] v);
    logic signed [OPERAND_WIDTH-1:0] t;
    t = v[OPERAND_WIDTH-1:0];
    return 64'(t);
  endfunction

  function automatic out_item_t reduce_fraction(in_item_t it);
    logic signed [63:0] an, ad, bn, bd, pn, pd;
    logic [31:0] n, d, r;
    out_item_t res;
    an = operand(it.a_num);
    ad = operand(it.a_den);
    bn = operand(it.b_num);
    bd = operand(it.b_den);
    case (op_t'(it.action))
      OP_ADD: begin pn = an * bd + ad * bn; pd = ad * bd; end
      OP_SUB: begin pn = an * bd - ad * bn; pd = ad * bd; end
      OP_MUL: begin pn = an * bn; pd = ad * bd; end
      default: begin pn = an * bd; pd = ad * bn; end
    endcase
    res = '0;
    res.raw_num = pn[31:0];
    res.raw_den = pd[31:0];
    n = pn[31:0];
    d = pd[31:0];
    while (d != 0) begin
      r = trunc_rem(n, d);
      n = d;
      d = r;
    end
    res.zero_gcd = (n == 0);
    if (n != 0) begin
      res.red_num = trunc_quot(res.raw_num, n);
      res.red_den = trunc_quot(res.raw_den, n);
      if (res.red_den[31]) begin
        res.red_num = -res.red_num;
        res.red_den = -res.red_den;
      end
    end
    return res;
  endfunction

  task automatic send_fraction(op_t op, logic [15:0] an, logic [15:0] ad,
                               logic [15:0] bn, logic [15:0] bd);
    in_item_t it;
    it.action = op;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fraction_q.push_back(reduce_fraction(it));
    in_valid <= 1'b0;
    // The block takes no new item until the result of this one is out, so this costs no rate.
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'($urandom_range(0, 20)) - 16'd10;
      1: return 16'($urandom_range(0, 600)) - 16'd300;
      2: return $urandom_range(1) ? 16'h7fff : 16'h8001;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count)
      send_fraction(op_t'($urandom_range(3)), rand_operand(), rand_operand(),
                    rand_operand(), rand_operand());
  endtask

  task automatic drain();
    while (fraction_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_fraction(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_fraction(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_fraction(OP_MUL, -16'sd2, 16'd4, 16'd3, -16'sd6);
    send_fraction(OP_DIV, 16'd3, 16'd4, -16'sd9, 16'd8);
    send_fraction(OP_ADD, 16'd0, 16'd0, 16'd0, 16'd0);
    send_fraction(OP_MUL, 16'd0, 16'd5, 16'd7, 16'd0);
    send_fraction(OP_DIV, 16'd5, 16'd3, 16'd0, 16'd2);
    send_fraction(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_fraction(OP_ADD, 16'h8001, 16'h7fff, 16'h8001, 16'h7fff);
    send_fraction(OP_SUB, 16'h7fff, 16'h8001, 16'h8001, 16'h7fff);
    // Operands of -32768 give extreme raw products; the add case wraps the raw numerator to the most negative value.
    send_fraction(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h0001);
    send_fraction(OP_MUL, 16'h8000, 16'h0001, 16'h0001, 16'hffff);
    send_fraction(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_fraction(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_fraction(OP_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fraction(OP_DIV, 16'd17711, 16'd28657, 16'd1, 16'd1);
    send_fraction(OP_SUB, 16'd0, -16'sd7, 16'd3, -16'sd5);
    send_fraction(OP_ADD, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa);
  endtask

  task automatic test_flow_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(60);
    send_idle_pct = 54; recv_stall_pct = 0;  send_random(60);
    send_idle_pct = 0;  recv_stall_pct = 54; send_random(60);
    send_idle_pct = 17; recv_stall_pct = 17; send_random(60);
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(60);
  endtask

  task automatic test_backpressure();
    // Hold the result channel off while the sender keeps offering transfers.
    hold_off = 1'b1;
    fork
      send_random(8);
      begin
        repeat (6000) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    send_random(40);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (fraction_q.size() == 0) begin
        $error("result transfer with no expected fraction");
        errors++;
      end else begin
        exp_res = fraction_q.pop_front();
        if (out_data.raw_num !== exp_res.raw_num) begin
          $error("raw_num expected %0d got %0d", exp_res.raw_num, out_data.raw_num);
          errors++;
        end
        if (out_data.raw_den !== exp_res.raw_den) begin
          $error("raw_den expected %0d got %0d", exp_res.raw_den, out_data.raw_den);
          errors++;
        end
        if (out_data.red_num !== exp_res.red_num) begin
          $error("red_num expected %0d got %0d", exp_res.red_num, out_data.red_num);
          errors++;
        end
        if (out_data.red_den !== exp_res.red_den) begin
          $error("red_den expected %0d got %0d", exp_res.red_den, out_data.red_den);
          errors++;
        end
        if (out_data.zero_gcd !== exp_res.zero_gcd) begin
          $error("zero_gcd expected %0d got %0d", exp_res.zero_gcd, out_data.zero_gcd);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_flow_phases();
    test_backpressure();
    drain();
    repeat (2000) @(posedge clk);
    if (errors == 0 && fraction_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- rational_arith_reduce.f -----
+incdir+design
design/rar_pkg.sv
design/rar_divider.sv
design/rar_datapath.sv
design/rar_ctrl.sv
design/rational_arith_reduce.sv
bench/tb_top.sv
